// ----- hdl/rgbf_pkg.sv -----
package rgbf_pkg;

  localparam int PIX_W     = 16;
  localparam int CH_W      = 8;
  localparam int FIELD_W   = 5;
  localparam int STEP_W    = 8;
  localparam int FRAC_BITS = 12;
  localparam int FACT_W    = FRAC_BITS + 1;
  localparam int CFG_IDX_W = 8;
  localparam int PROD_W    = CH_W + FACT_W;

  localparam logic [FACT_W-1:0] FULL_SCALE = FACT_W'(1) << FRAC_BITS;

  localparam int FIFO_DEPTH_DEF = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_COUNT   = 8'd0,
    REG_TARGET_RED   = 8'd1,
    REG_TARGET_GREEN = 8'd2,
    REG_TARGET_BLUE  = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLS_CLEAR,
    CLS_FILL,
    CLS_BLEND
  } pix_cls_t;

  typedef struct packed {
    logic [PIX_W-1:0]  pixel;
    logic              frame_end;
    pix_cls_t          cls;
    logic [FACT_W-1:0] factor;
  } q_entry_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W:0]   num;
    logic [STEP_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic [FACT_W-1:0] factor;
  } div_rsp_t;

endpackage

// ----- hdl/rgbf_if.sv -----
interface rgbf_in_if;
  logic                       valid;
  logic                       ready;
  logic [rgbf_pkg::PIX_W-1:0] pixel_in;
  logic                       frame_end;

  modport source(output valid, output pixel_in, output frame_end, input ready);
  modport sink(input valid, input pixel_in, input frame_end, output ready);
endinterface

interface rgbf_out_if;
  logic                       valid;
  logic                       ready;
  logic [rgbf_pkg::PIX_W-1:0] pixel_out;
  logic                       last_of_frame;

  modport source(output valid, output pixel_out, output last_of_frame, input ready);
  modport sink(input valid, input pixel_out, input last_of_frame, output ready);
endinterface

// ----- hdl/rgbf_div.sv -----
// Restoring divider for the blend factor: ((n << 12) / s), one quotient bit a cycle.
module rgbf_div import rgbf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [STEP_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0] den_r, den_nxt;
  logic [FACT_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [STEP_W:0]   shifted;
  logic              ge;

  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r, 1'b0};
    ge       = shifted >= {1'b0, den_r};
    if (req.start) begin
      den_nxt = req.den;
      if (req.num >= {1'b0, req.den}) begin
        // last step of the fade: factor saturates at full scale
        q_nxt    = FULL_SCALE;
        busy_nxt = 1'b0;
      end else begin
        rem_nxt  = req.num[STEP_W-1:0];
        q_nxt    = '0;
        cnt_nxt  = CNT_W'(FRAC_BITS);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? STEP_W'(shifted - {1'b0, den_r}) : shifted[STEP_W-1:0];
      q_nxt   = {q_r[FACT_W-2:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r    <= FULL_SCALE;
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      q_r    <= q_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy   = busy_r;
  assign rsp.factor = q_r;

endmodule

// ----- hdl/rgbf_front.sv -----
module rgbf_front import rgbf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  rgbf_in_if.sink           in_bus,
  input  logic [STEP_W-1:0] step_eff,
  input  logic              recalc,
  input  logic              fifo_full,
  input  div_rsp_t          div_rsp,
  output div_req_t          div_req,
  output logic              push,
  output q_entry_t          entry
);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              calc_req_r, calc_req_nxt;
  logic [STEP_W:0]   step_plus1;
  logic              is_final;
  logic              accept;

  assign step_plus1   = {1'b0, step_r} + (STEP_W+1)'(1);
  assign is_final     = step_plus1 >= {1'b0, step_eff};
  assign in_bus.ready = !calc_req_r && !div_rsp.busy && !fifo_full;
  assign accept       = in_bus.valid && in_bus.ready;
  assign push         = accept;

  assign div_req.start = calc_req_r && !div_rsp.busy;
  assign div_req.num   = step_plus1;
  assign div_req.den   = step_eff;

  always_comb begin
    step_nxt = step_r;
    if (accept && in_bus.frame_end) begin
      step_nxt = is_final ? '0 : step_plus1[STEP_W-1:0];
    end
    calc_req_nxt = (calc_req_r && !div_req.start) || (accept && in_bus.frame_end) || recalc;
  end

  always_comb begin
    entry.pixel     = in_bus.pixel_in;
    entry.frame_end = in_bus.frame_end;
    entry.factor    = div_rsp.factor;
    priority if (in_bus.pixel_in == '0) begin
      entry.cls = CLS_CLEAR;
    end else if (is_final) begin
      entry.cls = CLS_FILL;
    end else begin
      entry.cls = CLS_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      calc_req_r <= 1'b0;
    end else begin
      step_r     <= step_nxt;
      calc_req_r <= calc_req_nxt;
    end
  end

endmodule

// ----- hdl/rgbf_fifo.sv -----
// Word queue with a registered head; holds DEPTH words in memory plus one in the head.
module rgbf_fifo import rgbf_pkg::*; #(
  parameter int DEPTH = FIFO_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t wr_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t         mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             head_v_r, head_v_nxt;
  logic             load;

  assign full       = cnt_r == CNT_W'(DEPTH);
  assign load       = (cnt_r != '0) && (!head_v_r || pop);
  assign head_valid = head_v_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (load) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(load);
    head_v_nxt = load ? 1'b1 : (pop ? 1'b0 : head_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      head_v_r <= 1'b0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      head_v_r <= head_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
    if (load) begin
      head <= mem[rd_ptr_r];
    end
  end

endmodule

// ----- hdl/rgbf_back.sv -----
// Two stages: channel products, then sum and pack into the output register.
module rgbf_back import rgbf_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  q_entry_t        head,
  output logic            pop,
  input  logic [CH_W-1:0] target_red,
  input  logic [CH_W-1:0] target_green,
  input  logic [CH_W-1:0] target_blue,
  rgbf_out_if.source      out_bus
);

  localparam int NCH = 3;

  logic [FACT_W-1:0] comp;
  logic [CH_W-1:0]   src_ch [NCH];
  logic [CH_W-1:0]   tgt_ch [NCH];
  logic [PROD_W-1:0] src_p_r [NCH];
  logic [PROD_W-1:0] tgt_p_r [NCH];
  logic [PIX_W-1:0]  s1_pixel_r;
  logic              s1_fe_r;
  pix_cls_t          s1_cls_r;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_ready, s2_ready;
  logic [PROD_W-1:0] sum [NCH];
  logic [FIELD_W-1:0] blend_ch [NCH];
  logic [PIX_W-1:0]  res;
  logic [PIX_W-1:0]  out_pixel_r;
  logic              out_fe_r;
  logic              out_v_r, out_v_nxt;

  assign s2_ready = !out_v_r || out_bus.ready;
  assign s1_ready = !s1_v_r || s2_ready;
  assign pop      = head_valid && s1_ready;

  assign comp      = FULL_SCALE - head.factor;
  assign src_ch[0] = {head.pixel[4:0], 3'b000};
  assign src_ch[1] = {head.pixel[9:5], 3'b000};
  assign src_ch[2] = {head.pixel[14:10], 3'b000};
  assign tgt_ch[0] = target_red;
  assign tgt_ch[1] = target_green;
  assign tgt_ch[2] = target_blue;

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int i = 0; i < NCH; i++) begin
        src_p_r[i] <= {{FACT_W{1'b0}}, src_ch[i]} * {{CH_W{1'b0}}, comp};
        tgt_p_r[i] <= {{FACT_W{1'b0}}, tgt_ch[i]} * {{CH_W{1'b0}}, head.factor};
      end
      s1_pixel_r <= head.pixel;
      s1_fe_r    <= head.frame_end;
      s1_cls_r   <= head.cls;
    end
  end

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      sum[i]      = src_p_r[i] + tgt_p_r[i];
      // the blend is at most 255 * 4096, so bits 19:15 carry the 5-bit field
      blend_ch[i] = sum[i][19:15];
    end
    unique case (s1_cls_r)
      CLS_CLEAR: res = '0;
      CLS_FILL:  res = {1'b1, target_blue[7:3], target_green[7:3], target_red[7:3]};
      CLS_BLEND: res = {s1_pixel_r[15], blend_ch[2], blend_ch[1], blend_ch[0]};
      default:   res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      out_pixel_r <= res;
      out_fe_r    <= s1_fe_r;
    end
  end

  always_comb begin
    s1_v_nxt  = pop ? 1'b1 : (s2_ready ? 1'b0 : s1_v_r);
    out_v_nxt = s2_ready ? s1_v_r : out_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_bus.valid         = out_v_r;
  assign out_bus.pixel_out     = out_pixel_r;
  assign out_bus.last_of_frame = out_fe_r;

endmodule

// ----- hdl/rgb555_fade_to_color_unit.sv -----
// Fades a stream of RGB555 pixels toward a target color, one frame pass per fade step.
// Within a frame the unit takes one pixel per clock while the queue is not full. After
// each word that carries frame_end, and after a write of step_count, input stalls while
// the blend factor is computed by a restoring divider one quotient bit a cycle, or set
// to full scale when the step it is computed for is the last one (factor saturates).
// A taken pixel passes through the queue memory, the queue head, the channel-product
// register and the output register before it is presented at the output.
module rgb555_fade_to_color_unit import rgbf_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rgbf_in_if.sink              in_bus,
  rgbf_out_if.source           out_bus,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CH_W-1:0]      cfg_wdata
);

  logic [STEP_W-1:0] step_count_r;
  logic [CH_W-1:0]   target_red_r;
  logic [CH_W-1:0]   target_green_r;
  logic [CH_W-1:0]   target_blue_r;
  logic [STEP_W-1:0] step_eff;
  logic              recalc;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              push;
  logic              fifo_full;
  q_entry_t          wr_entry;
  logic              head_valid;
  q_entry_t          head;
  logic              pop;

  // a step count of zero behaves as one
  assign step_eff = (step_count_r == '0) ? STEP_W'(1) : step_count_r;
  assign recalc   = cfg_we && (cfg_idx == REG_STEP_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_count_r   <= STEP_W'(1);
      target_red_r   <= '0;
      target_green_r <= '0;
      target_blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_STEP_COUNT:   step_count_r   <= cfg_wdata;
        REG_TARGET_RED:   target_red_r   <= cfg_wdata;
        REG_TARGET_GREEN: target_green_r <= cfg_wdata;
        REG_TARGET_BLUE:  target_blue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rgbf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  rgbf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .step_eff  (step_eff),
    .recalc    (recalc),
    .fifo_full (fifo_full),
    .div_rsp   (div_rsp),
    .div_req   (div_req),
    .push      (push),
    .entry     (wr_entry)
  );

  rgbf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .wr_entry   (wr_entry),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  rgbf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .target_red   (target_red_r),
    .target_green (target_green_r),
    .target_blue  (target_blue_r),
    .out_bus      (out_bus)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_while_div: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_bus.valid && in_bus.ready && div_rsp.busy))
    else $error("pixel taken while blend factor is being computed");

  a_stall_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready && in_bus.frame_end) |=> !in_bus.ready)
    else $error("input not stalled after end of frame");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && fifo_full))
    else $error("queue written while full");

  a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");
`endif

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rgbf_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int SETTLE_CYCLES = 24;   // divider plus pipeline, with margin
  localparam int HOLD_AT       = 500;  // input words taken before the long back-pressure
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_WORDS  = 1400;
  localparam int MAX_PRINT     = 50;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } fade_word_t;

  class fade_scoreboard;
    logic [STEP_W-1:0] step_count;
    logic [CH_W-1:0]   tgt_r, tgt_g, tgt_b;
    logic [STEP_W-1:0] step_idx;
    logic [FACT_W-1:0] factor;
    fade_word_t        expected_q[$];
    int                errors;

    function new();
      step_count = 8'd1;
      tgt_r      = '0;
      tgt_g      = '0;
      tgt_b      = '0;
      step_idx   = '0;
      errors     = 0;
      refresh_factor();
    endfunction

    function int unsigned eff_steps();
      return (step_count == 0) ? 1 : int'(step_count);
    endfunction

    function bit last_step();
      return (int'(step_idx) + 1) >= eff_steps();
    endfunction

    function void refresh_factor();
      int unsigned q;
      q = ((int'(step_idx) + 1) << FRAC_BITS) / eff_steps();
      factor = (q > int'(FULL_SCALE)) ? FULL_SCALE : FACT_W'(q);
    endfunction

    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CH_W-1:0] val);
      case (idx)
        REG_STEP_COUNT: begin
          step_count = val;
          refresh_factor();
        end
        REG_TARGET_RED:   tgt_r = val;
        REG_TARGET_GREEN: tgt_g = val;
        REG_TARGET_BLUE:  tgt_b = val;
        default: ;
      endcase
    endfunction

    // Blend one accepted pixel and advance the fade step on frame_end.
    function void note_input(logic [PIX_W-1:0] px, logic fe);
      fade_word_t  w;
      int unsigned p, f, c, rs, gs, bs, r, g, b, res;
      p = px;
      if (p == 0) begin
        res = 0;
      end else if (last_step()) begin
        res = 32'h8000 | (int'(tgt_r) >> 3) | ((int'(tgt_g) & 32'hF8) << 2)
            | ((int'(tgt_b) & 32'hF8) << 7);
      end else begin
        f   = factor;
        c   = int'(FULL_SCALE) - f;
        rs  = (p & 32'h1F) << 3;
        gs  = (p >> 2) & 32'hF8;
        bs  = (p >> 7) & 32'hF8;
        r   = ((rs * c + int'(tgt_r) * f) >> 15) & 32'h1F;
        g   = ((gs * c + int'(tgt_g) * f) >> 10) & 32'h3E0;
        b   = ((bs * c + int'(tgt_b) * f) >> 5) & 32'h7C00;
        res = (p & 32'h8000) | r | g | b;
      end
      w.pixel = PIX_W'(res);
      w.last  = fe;
      expected_q.push_back(w);
      if (fe) begin
        if (last_step()) step_idx = '0;
        else step_idx = step_idx + 8'd1;
        refresh_factor();
      end
    endfunction

    task report_mismatch(string msg);
      errors++;
      // keep the log short if the block is badly broken
      if (errors <= MAX_PRINT) $display("MISMATCH: %s", msg);
    endtask

    task check_output(logic [PIX_W-1:0] px, logic last);
      fade_word_t w;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word pixel=%h last=%b", px, last));
      end else begin
        w = expected_q.pop_front();
        if (px !== w.pixel)
          report_mismatch($sformatf("pixel_out got %h want %h", px, w.pixel));
        if (last !== w.last)
          report_mismatch($sformatf("last_of_frame got %b want %b (pixel %h)",
                                    last, w.last, w.pixel));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CH_W-1:0]      cfg_wdata;

  rgbf_in_if  in_if ();
  rgbf_out_if out_if ();

  rgb555_fade_to_color_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_if),
    .out_bus   (out_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  fade_scoreboard sb = new();

  int words_taken = 0;
  bit hold_done   = 1'b0;
  bit no_idle     = 1'b0;

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready)
        sb.check_output(out_if.pixel_out, out_if.last_of_frame);
      if (in_if.valid && in_if.ready) begin
        sb.note_input(in_if.pixel_in, in_if.frame_end);
        words_taken++;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return '0;
    if (r < 25) begin
      case ($urandom_range(0, 6))
        0: return 16'hFFFF;
        1: return 16'h7FFF;
        2: return 16'h8000;
        3: return 16'h0001;
        4: return 16'h001F;
        5: return 16'h03E0;
        default: return 16'h7C00;
      endcase
    end
    return PIX_W'($urandom);
  endfunction

  function automatic logic [CH_W-1:0] rand_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return CH_W'($urandom);
  endfunction

  function automatic logic [STEP_W-1:0] rand_steps();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    if (r < 26) return 8'd1;
    if (r < 40) return 8'd2;
    return STEP_W'($urandom_range(3, 10));
  endfunction

  function automatic int rand_frame_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, 40);
  endfunction

  // Offer one word; returns right after the edge that accepted it.
  task automatic send_word(input logic [PIX_W-1:0] px, input logic fe);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.pixel_in  <= px;
    in_if.frame_end <= fe;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    // one edge so the monitor has noted the last accepted word
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CH_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.apply_write(idx, val);
  endtask

  task automatic configure(input logic [STEP_W-1:0] steps, input logic [CH_W-1:0] r,
                           input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                           input bit junk);
    drain();
    write_reg(REG_STEP_COUNT, steps);
    write_reg(REG_TARGET_RED, r);
    write_reg(REG_TARGET_GREEN, g);
    write_reg(REG_TARGET_BLUE, b);
    // index outside the register map, must be dropped
    if (junk) write_reg(CFG_IDX_W'($urandom_range(4, 255)), CH_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int n_words);
    int   flen, k;
    logic fe;
    configure(rand_steps(), rand_chan(), rand_chan(), rand_chan(),
              $urandom_range(0, 4) == 0);
    no_idle = ($urandom_range(0, 3) == 0);
    flen = rand_frame_len();
    k = 0;
    repeat (n_words) begin
      k++;
      fe = (k >= flen);
      send_word(rand_pixel(), fe);
      if (fe) begin
        k = 0;
        flen = rand_frame_len();
      end
    end
  endtask

  initial begin : sink_proc
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (!hold_done && words_taken >= HOLD_AT) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (stall > 0) begin
        out_if.ready <= 1'b0;
        stall--;
        @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) stall = pick_gap();
        @(posedge clk);
      end
    end
  end

  initial begin : stim_proc
    int sent, n;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.pixel_in  = '0;
    in_if.frame_end = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: one step, black target, every nonzero pixel fills
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h1234, 1'b1);

    // four steps toward white, the fourth one fills
    configure(8'd4, 8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_word(16'h7FFF, 1'b0);
    send_word(16'h8000, 1'b1);
    send_word(16'h0001, 1'b0);
    send_word(16'h001F, 1'b1);
    send_word(16'h03E0, 1'b0);
    send_word(16'h7C00, 1'b1);
    send_word(16'h0000, 1'b0);
    send_word(16'hFFFF, 1'b1);

    // zero step count behaves as one; stray register index ignored
    configure(8'd0, 8'h12, 8'h80, 8'hF8, 1'b1);
    send_word(16'h5555, 1'b0);
    send_word(16'hAAAA, 1'b1);

    // walk a long fade a few steps, then shrink it so the step is already past the end
    configure(8'd8, 8'hFF, 8'h00, 8'h80, 1'b0);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h7FFF, 1'b1);
    send_word(16'h7FFF, 1'b1);
    configure(8'd2, 8'hFF, 8'h00, 8'h80, 1'b0);
    send_word(16'h4210, 1'b0);
    send_word(16'h0421, 1'b1);
    send_word(16'h7FFF, 1'b1);

    // register change inside a frame
    send_word(16'h1111, 1'b0);
    configure(8'd3, 8'h00, 8'hFF, 8'h00, 1'b0);
    send_word(16'h2222, 1'b1);

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      n = $urandom_range(40, 120);
      random_phase(n);
      sent += n;
    end

    drain();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/rgbf_pkg.sv
hdl/rgbf_if.sv
hdl/rgbf_div.sv
hdl/rgbf_front.sv
hdl/rgbf_fifo.sv
hdl/rgbf_back.sv
hdl/rgb555_fade_to_color_unit.sv
dv/tb.sv
